// ===== src/idr_pkg.sv =====
package idr_pkg;

  // header layout and protocol constants
  localparam int unsigned HEADER_BYTES = 12;
  localparam logic [31:0] IMAGE_MAGIC   = 32'h4D43_544F;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [20:0] LEN_CEILING   = 21'd1048576;
  localparam logic [20:0] MAX_LEN_RESET = 21'd843776;

  // command codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_ABORT = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // session status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH   = 3'd2;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd3;
  localparam logic [2:0] ST_ABORTED      = 3'd4;

  // result queue depth
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_IDLE    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } idr_in_t;

  typedef struct packed {
    logic        kind;
    logic [19:0] offset;
    logic [7:0]  payload;
    logic [2:0]  status;
    logic        last;
  } idr_out_t;

  // results produced by one request, written to the queue together
  typedef struct packed {
    logic [1:0] cnt;
    idr_out_t   r0;
    idr_out_t   r1;
  } idr_push_t;

  // reflected crc-32 update over one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'b0);
    end
    return c;
  endfunction

endpackage

// ===== src/idr_session.sv =====
module idr_session import idr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  idr_in_t     item,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  output idr_push_t   push
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [31:0] img_len_r, img_len_nxt;
  logic [31:0] exp_crc_r, exp_crc_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [19:0] offset_r, offset_nxt;
  logic [20:0] max_len_r;

  logic [20:0] lim;
  logic [31:0] byte_sh;
  logic [4:0]  sh_amt;
  logic [31:0] crc_new;
  logic [20:0] off_inc;

  // configured limit, saturated to the offset span
  assign lim = (max_len_r > LEN_CEILING) ? LEN_CEILING : max_len_r;

  assign sh_amt  = {hdr_cnt_r[1:0], 3'b000};
  assign byte_sh = {24'b0, item.data_byte} << sh_amt;
  assign crc_new = crc32_byte(crc_r, item.data_byte);
  assign off_inc = {1'b0, offset_r} + 21'd1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      magic_r   <= '0;
      img_len_r <= '0;
      exp_crc_r <= '0;
      crc_r     <= CRC_INIT;
      offset_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      magic_r   <= magic_nxt;
      img_len_r <= img_len_nxt;
      exp_crc_r <= exp_crc_nxt;
      crc_r     <= crc_nxt;
      offset_r  <= offset_nxt;
    end
  end

  // request decode, header parse, crc and result build
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    magic_nxt   = magic_r;
    img_len_nxt = img_len_r;
    exp_crc_nxt = exp_crc_r;
    crc_nxt     = crc_r;
    offset_nxt  = offset_r;
    push        = '0;
    if (fire) begin
      case (item.command)
        CMD_START: begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = '0;
          magic_nxt   = '0;
          img_len_nxt = '0;
          exp_crc_nxt = '0;
          crc_nxt     = CRC_INIT;
          offset_nxt  = '0;
        end
        CMD_ABORT: begin
          if (phase_r == PH_HEADER || phase_r == PH_PAYLOAD) begin
            phase_nxt        = PH_IDLE;
            push.cnt         = 2'd1;
            push.r0.kind     = KIND_STATUS;
            push.r0.status   = ST_ABORTED;
            push.r0.last     = 1'b1;
          end
        end
        CMD_BYTE: begin
          case (phase_r)
            PH_HEADER: begin
              case (hdr_cnt_r[3:2])
                2'd0:    magic_nxt   = magic_r | byte_sh;
                2'd1:    img_len_nxt = img_len_r | byte_sh;
                default: exp_crc_nxt = exp_crc_r | byte_sh;
              endcase
              hdr_cnt_nxt = hdr_cnt_r + 4'd1;
              if (hdr_cnt_nxt == 4'(HEADER_BYTES)) begin
                if (magic_nxt != IMAGE_MAGIC) begin
                  phase_nxt      = PH_IDLE;
                  push.cnt       = 2'd1;
                  push.r0.kind   = KIND_STATUS;
                  push.r0.status = ST_BAD_MAGIC;
                  push.r0.last   = 1'b1;
                end else if (img_len_nxt == 32'd0 || img_len_nxt > {11'b0, lim}) begin
                  phase_nxt      = PH_IDLE;
                  push.cnt       = 2'd1;
                  push.r0.kind   = KIND_STATUS;
                  push.r0.status = ST_BAD_LENGTH;
                  push.r0.last   = 1'b1;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              crc_nxt         = crc_new;
              offset_nxt      = off_inc[19:0];
              push.r0.kind    = KIND_DATA;
              push.r0.offset  = offset_r;
              push.r0.payload = item.data_byte;
              if ({11'b0, off_inc} >= img_len_r) begin
                phase_nxt      = PH_IDLE;
                push.cnt       = 2'd2;
                push.r1.kind   = KIND_STATUS;
                push.r1.status = (~crc_new == exp_crc_r) ? ST_OK : ST_CRC_MISMATCH;
                push.r1.last   = 1'b1;
              end else begin
                push.cnt     = 2'd1;
                push.r0.last = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // header counter never runs past the header while collecting it
  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (hdr_cnt_r < 4'(HEADER_BYTES)))
    else $error("header count beyond header");

  // payload offset stays inside the announced image
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> ({12'b0, offset_r} < img_len_r))
    else $error("payload offset outside image");

  // a pair of results is a data byte followed by the closing status
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.r0.kind == KIND_DATA && !push.r0.last &&
                            push.r1.kind == KIND_STATUS && push.r1.last))
    else $error("malformed result pair");

  // any result closes the session except a non-final data byte
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0 && push.r0.kind == KIND_STATUS) |=> (phase_r == PH_IDLE))
    else $error("status result without closing session");
`endif

endmodule

// ===== src/idr_res_fifo.sv =====
module idr_res_fifo import idr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  idr_push_t push,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_ready,
  output idr_out_t  out_data
);

  localparam int unsigned PW = $clog2(RES_DEPTH);

  idr_out_t      mem_r [RES_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room2     = (count_r <= (PW+1)'(RES_DEPTH - 2));
  assign wr_ptr1   = wr_ptr_r + 1'b1;

  assign count_nxt = count_r + {{(PW-1){1'b0}}, push.cnt} - {{PW{1'b0}}, pop};

  // result storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.cnt[PW-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count bounded by depth
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(RES_DEPTH))
    else $error("result queue overflow");

  // pointers stay consistent with the fill count
  a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[PW-1:0])
    else $error("queue pointers out of step with count");

  // a pair is only written when room for two was reported
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> $past(room2) || room2)
    else $error("push without room");
`endif

endmodule

// ===== src/image_download_receiver_core.sv =====
// Image download receiver: parses a 12-byte little-endian header (magic,
// length, expected crc-32), passes payload bytes out with their offsets and
// closes each finished, failed or aborted session with one status result.
// Input channel in_valid/in_ready carries one request per accepted cycle:
// a stream byte, an abort or a session start. Result channel
// out_valid/out_ready carries data results (kind 0) and status results
// (kind 1); last marks the final result caused by a request.
// cfg_we/cfg_wdata write the maximum image length at any edge with cfg_we.
// Throughput: one request per cycle while the queue has room for two
// results. A request is held in the input register, processed there by
// the header/crc logic (a byte-wide crc update) and written into a
// four-entry result queue, which offers its results on the output channel.
// The final payload byte writes two results into the queue at once.
// A request is processed only while the queue has room for two results;
// when the receiver stalls, the queue fills and in_ready drops, and no
// result is lost or repeated.
// Reset: the session opens waiting for a header, the length limit returns
// to its default, the queue empties. No clearing pass is needed.
module image_download_receiver_core import idr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  idr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output idr_out_t    out_data,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata
);

  logic      item_valid_r;
  idr_in_t   item_r;
  logic      fire;
  logic      room2;
  idr_push_t push;

  // the held request is processed when two result slots are free
  assign fire     = item_valid_r && room2;
  assign in_ready = !item_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  idr_session u_session (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  idr_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // a held request waits only for queue room
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !room2) |=> item_valid_r && $stable(item_r))
    else $error("held request lost");

  // a held request is taken as soon as the queue has room
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && room2) |-> in_ready)
    else $error("ready low with room available");

  // results only appear after a request was processed
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> fire)
    else $error("result without request");
`endif

endmodule

// ===== sim/image_download_receiver_core_tb.sv =====
module image_download_receiver_core_tb;
  import idr_pkg::*;

  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_REQUESTS = 1600;
  localparam int unsigned CONFIG_INTERVAL = 250;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  idr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  idr_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [20:0] cfg_wdata = '0;

  image_download_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8-unit clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // session state mirror and length limit
  phase_t      session_phase;
  logic [3:0]  hdr_count;
  logic [31:0] hdr_magic;
  logic [31:0] img_len;
  logic [31:0] img_crc;
  logic [31:0] run_crc;
  logic [19:0] byte_off;
  logic [20:0] max_len;

  idr_out_t    pending_results[$];
  int unsigned live_requests = 0;
  int unsigned error_count = 0;
  int unsigned stalled_cycles = 0;
  int unsigned stall_left = 0;
  bit          steady_flow = 1'b0;

  // reflected crc-32, one bit at a time
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // effective length limit: register value saturated at the offset span
  function automatic logic [31:0] length_limit();
    return (max_len > LEN_CEILING) ? 32'(LEN_CEILING) : 32'(max_len);
  endfunction

  // mostly short waits, now and then a long one
  function automatic int unsigned wait_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_session();
    session_phase = PH_HEADER;
    hdr_count = '0;
    hdr_magic = '0;
    img_len = '0;
    img_crc = '0;
    run_crc = CRC_INIT;
    byte_off = '0;
  endtask

  task automatic expect_payload(input logic [19:0] off, input logic [7:0] b,
                                input logic lst);
    idr_out_t r;
    r = '{kind: KIND_DATA, offset: off, payload: b, status: ST_OK, last: lst};
    pending_results.push_back(r);
  endtask

  task automatic expect_status(input logic [2:0] st);
    idr_out_t r;
    r = '{kind: KIND_STATUS, offset: '0, payload: '0, status: st, last: 1'b1};
    pending_results.push_back(r);
  endtask

  // advance the session by one accepted request, queue what it produces
  task automatic compute_session_results(input idr_in_t req);
    logic [3:0]  idx;
    logic [31:0] word;
    logic [19:0] off;
    if (req.command == CMD_START ||
        (req.command != CMD_UNUSED && session_phase != PH_IDLE))
      live_requests++;
    case (req.command)
      CMD_START: clear_session();
      CMD_ABORT: begin
        if (session_phase == PH_HEADER || session_phase == PH_PAYLOAD) begin
          session_phase = PH_IDLE;
          expect_status(ST_ABORTED);
        end
      end
      CMD_BYTE: begin
        if (session_phase == PH_HEADER) begin
          idx = hdr_count;
          word = 32'(req.data_byte) << (8 * idx[1:0]);
          if (idx < 4) hdr_magic = hdr_magic | word;
          else if (idx < 8) img_len = img_len | word;
          else img_crc = img_crc | word;
          hdr_count = idx + 4'd1;
          if (hdr_count == 4'(HEADER_BYTES)) begin
            if (hdr_magic != IMAGE_MAGIC) begin
              session_phase = PH_IDLE;
              expect_status(ST_BAD_MAGIC);
            end else if (img_len == 0 || img_len > length_limit()) begin
              session_phase = PH_IDLE;
              expect_status(ST_BAD_LENGTH);
            end else begin
              session_phase = PH_PAYLOAD;
            end
          end
        end else if (session_phase == PH_PAYLOAD) begin
          off = byte_off;
          run_crc = crc_update(run_crc, req.data_byte);
          byte_off = off + 20'd1;
          if (32'(off) + 1 >= img_len) begin
            session_phase = PH_IDLE;
            expect_payload(off, req.data_byte, 1'b0);
            expect_status((~run_crc == img_crc) ? ST_OK : ST_CRC_MISMATCH);
          end else begin
            expect_payload(off, req.data_byte, 1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // one request on the input channel, with a random gap ahead of it
  task automatic send_request(input idr_in_t req);
    int unsigned gap;
    gap = (steady_flow || $urandom_range(0, 99) < 55) ? 0 : wait_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    compute_session_results(req);
  endtask

  task automatic send_byte(input logic [7:0] b);
    idr_in_t req;
    req.command = CMD_BYTE;
    req.data_byte = b;
    send_request(req);
  endtask

  task automatic send_command(input logic [1:0] cmd);
    idr_in_t req;
    req.command = cmd;
    req.data_byte = 8'($urandom);
    send_request(req);
  endtask

  task automatic send_header(input logic [31:0] magic, input logic [31:0] len,
                             input logic [31:0] crc);
    logic [95:0] hdr;
    hdr = {crc, len, magic};
    for (int i = 0; i < int'(HEADER_BYTES); i++) send_byte(hdr[8*i +: 8]);
  endtask

  // start, header, then body_len random body bytes; crc taken over the body
  task automatic send_session(input logic [31:0] magic, input logic [31:0] len,
                              input int unsigned body_len, input logic [31:0] crc_flip);
    logic [7:0]  body[$];
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < int'(body_len); i++) begin
      body.push_back(8'($urandom));
      c = crc_update(c, body[i]);
    end
    send_command(CMD_START);
    send_header(magic, len, ~c ^ crc_flip);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // drop valid and wait for every pending result, plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [20:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len = v;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  // one-byte image, ignored requests while idle, start over an open session
  task automatic test_directed_cases();
    idr_in_t req;
    send_header(IMAGE_MAGIC, 32'd1, ~crc_update(CRC_INIT, 8'hFF));
    send_byte(8'hFF);
    req.command = CMD_UNUSED;
    req.data_byte = 8'h00;
    send_request(req);
    send_command(CMD_ABORT);
    send_byte(8'h00);
    send_command(CMD_START);
    repeat (5) send_byte(8'($urandom));
    send_command(CMD_START);
    send_command(CMD_ABORT);
    settle();
  endtask

  // register extremes and the boundary lengths around them
  task automatic test_length_limits();
    write_max_len(21'd0);
    send_session(IMAGE_MAGIC, 32'd1, 0, '0);
    send_session(IMAGE_MAGIC, 32'd0, 0, '0);
    settle();
    write_max_len('1);
    send_session(IMAGE_MAGIC, 32'd1048577, 0, '0);
    send_session(IMAGE_MAGIC, 32'd1048576, 3, '0);
    send_command(CMD_ABORT);
    settle();
    write_max_len(LEN_CEILING);
    send_session(IMAGE_MAGIC, 32'd1048576, 2, '0);
    send_command(CMD_ABORT);
    send_session(IMAGE_MAGIC, 32'hFFFF_FFFF, 0, '0);
    settle();
    write_max_len(21'd5);
    send_session(IMAGE_MAGIC, 32'd5, 5, '0);
    send_session(IMAGE_MAGIC, 32'd6, 0, '0);
    send_session(IMAGE_MAGIC, 32'd5, 5, 32'h8000_0000);
    send_session(IMAGE_MAGIC ^ 32'h0000_0100, 32'd5, 0, '0);
    settle();
  endtask

  // mostly well-formed sessions with random content, some broken ones and noise
  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned next_cfg;
    int unsigned pick;
    int unsigned cap;
    logic [31:0] lim;
    logic [31:0] len;
    logic [31:0] flip;
    int unsigned body_len;
    stop_at = live_requests + RANDOM_REQUESTS;
    next_cfg = live_requests + CONFIG_INTERVAL;
    while (live_requests < stop_at) begin
      if (live_requests >= next_cfg) begin
        settle();
        pick = $urandom_range(0, 9);
        if (pick == 0) write_max_len(21'd0);
        else if (pick == 1) write_max_len('1);
        else if (pick == 2) write_max_len(21'($urandom));
        else write_max_len(21'($urandom_range(1, 120)));
        next_cfg = live_requests + CONFIG_INTERVAL;
      end
      steady_flow = ($urandom_range(0, 9) == 0);
      lim = length_limit();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: any command, any byte
        repeat ($urandom_range(1, 6)) begin
          send_command(2'($urandom_range(0, 3)));
          if ($urandom_range(0, 1) == 1) send_byte(8'($urandom));
        end
      end else if (pick < 16) begin
        if ($urandom_range(0, 1) == 1) flip = 32'd1 << $urandom_range(0, 31);
        else flip = $urandom;
        send_session(IMAGE_MAGIC ^ flip, 32'($urandom_range(1, 20)), 0, '0);
      end else if (pick < 24 || lim == 0) begin
        if (lim == 0 || $urandom_range(0, 2) == 0) len = 32'd0;
        else if ($urandom_range(0, 3) == 0) len = 32'hFFFF_FFFF;
        else len = lim + 1 + $urandom_range(0, 1000);
        send_session(IMAGE_MAGIC, len, 0, '0);
      end else begin
        cap = ($urandom_range(0, 9) == 0) ? 200 : 16;
        if (lim < cap) cap = lim;
        len = $urandom_range(1, cap);
        flip = ($urandom_range(0, 4) == 0) ? (32'd1 << $urandom_range(0, 31)) : '0;
        if ($urandom_range(0, 9) == 0) begin
          // cut short by abort or a fresh start
          body_len = $urandom_range(0, len - 1);
          send_session(IMAGE_MAGIC, len, body_len, flip);
          send_command(($urandom_range(0, 1) == 1) ? CMD_ABORT : CMD_START);
        end else begin
          send_session(IMAGE_MAGIC, len, len, flip);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // result side: random stalls, long ones now and then
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      stall_left <= wait_length() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result against the oldest pending one
  always @(posedge clk) begin
    idr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: %p", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(out_data.kind));
        compare_field("offset", 32'(want.offset), 32'(out_data.offset));
        compare_field("payload", 32'(want.payload), 32'(out_data.payload));
        compare_field("status", 32'(want.status), 32'(out_data.status));
        compare_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // cycles with no handshake on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
  end

  initial begin
    wait (stalled_cycles >= STALL_LIMIT);
    $display("** image_download_receiver_core: FAILED **");
    $finish;
  end

  initial begin
    clear_session();
    max_len = MAX_LEN_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_length_limits();
    test_random_traffic();
    settle();
    if (error_count == 0) begin
      $display("** image_download_receiver_core: PASSED **");
    end else begin
      $display("** image_download_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/idr_pkg.sv
src/idr_session.sv
src/idr_res_fifo.sv
src/image_download_receiver_core.sv
sim/image_download_receiver_core_tb.sv
